// File: sv/pixel_normalize_to_tensor_assert.svh
// assertion macros for the pixel normaliser rtl
`ifndef PIXEL_NORMALIZE_TO_TENSOR_ASSERT_SVH
`define PIXEL_NORMALIZE_TO_TENSOR_ASSERT_SVH
`ifndef SYNTHESIS
`define PNT_ASSERT_IMP(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("pnt assertion failed");
`define PNT_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("pnt assertion failed");
`else
`define PNT_ASSERT_IMP(name, clk, rst, pre, post)
`define PNT_ASSERT_NEXT(name, clk, rst, pre, post)
`endif
`endif

// File: sv/pnt_pkg.sv
// types, constants and float helpers for the pixel normaliser
`default_nettype none
package pnt_pkg;

   localparam int unsigned MAX_PLANE = 16777216;
   localparam int unsigned PLANE_W   = 25;
   localparam int unsigned IDX_W     = 34;
   localparam int unsigned RUN_W     = 27;

   localparam int unsigned MODE_THREE = 0;
   localparam int unsigned MODE_NCHW  = 1;
   localparam int unsigned MODE_HALF  = 2;
   localparam int unsigned MODE_REV   = 3;

   localparam logic [31:0] QNAN32  = 32'h7FC0_0000;
   localparam logic [31:0] ONE32   = 32'h3F80_0000;
   localparam logic [30:0] INF32   = 31'h7F80_0000;
   localparam logic [15:0] QNAN16  = 16'h7E00;
   localparam logic [15:0] INF16   = 16'h7C00;

   typedef enum logic [2:0] {
      REG_MODE,
      REG_PLANE,
      REG_SCALE0,
      REG_SCALE1,
      REG_SCALE2,
      REG_BIAS0,
      REG_BIAS1,
      REG_BIAS2
   } pnt_reg_type;

   typedef struct packed {
      logic [3:0]         mode;
      logic [PLANE_W-1:0] plane_size;
      logic [2:0][31:0]   scale;
      logic [2:0][31:0]   bias;
   } pnt_cfg_type;

   typedef struct packed {
      logic [IDX_W-1:0] element_index;
      logic             is_last;
      logic             half;
   } pnt_meta_type;

   typedef struct packed {
      pnt_meta_type meta;
      logic [31:0]  bias;
   } pnt_tag_type;

   // unrounded value: mag * 2^expo, or a ready-made special pattern
   typedef struct packed {
      logic               special;
      logic [31:0]        spec_bits;
      logic               sign;
      logic [31:0]        mag;
      logic signed [11:0] expo;
   } pnt_unr_type;

   function automatic logic [5:0] lzc32(input logic [31:0] v);
      logic [5:0] n;
      n = 6'd32;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) begin
            n = 6'(31 - i);
         end
      end
      return n;
   endfunction

   function automatic logic [31:0] round_shift(input logic [31:0] m, input logic [4:0] s);
      logic [31:0] q;
      logic [31:0] rem;
      logic [31:0] hf;
      q   = m >> s;
      rem = m & ((32'd1 << s) - 32'd1);
      hf  = 32'd1 << (s - 5'd1);
      if (rem > hf || (rem == hf && q[0])) begin
         q = q + 32'd1;
      end
      return q;
   endfunction

   function automatic logic [15:0] to_half(input logic [31:0] x);
      logic [15:0] sgn;
      logic [7:0]  ex;
      logic [22:0] man;
      logic [15:0] r;
      sgn = {x[31], 15'b0};
      ex  = x[30:23];
      man = x[22:0];
      if (ex == 8'hFF) begin
         r = (man != 23'd0) ? QNAN16 : (sgn | INF16);
      end else if (ex > 8'd142) begin
         r = sgn | INF16;
      end else if (ex >= 8'd113) begin
         r = sgn | 16'(round_shift({4'b0, 5'(ex - 8'd112), man}, 5'd13));
      end else if (ex == 8'd0 || ex < 8'd102) begin
         r = sgn;
      end else begin
         r = sgn | 16'(round_shift({8'b0, 1'b1, man}, 5'(8'd126 - ex)));
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// File: sv/pnt_if.sv
// request and response channel interfaces
`default_nettype none
interface pnt_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  chan_a;
   logic [7:0]  chan_b;
   logic [7:0]  chan_c;
   logic [23:0] pixel_index;
   logic [7:0]  image_index;
   logic [31:0] base_index;
   modport source (output valid, chan_a, chan_b, chan_c, pixel_index, image_index,
                   base_index, input ready);
   modport sink (input valid, chan_a, chan_b, chan_c, pixel_index, image_index,
                 base_index, output ready);
endinterface

interface pnt_rsp_if;
   logic        valid;
   logic        ready;
   logic [33:0] element_index;
   logic [31:0] value;
   logic        is_last;
   modport source (output valid, element_index, value, is_last, input ready);
   modport sink (input valid, element_index, value, is_last, output ready);
endinterface
`default_nettype wire

// File: sv/pnt_chan_seq.sv
// pixel intake and per-channel sequencer with index generation
`default_nettype none
`include "pixel_normalize_to_tensor_assert.svh"
module pnt_chan_seq (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            en,
   input  wire pnt_pkg::pnt_cfg_type cfg,
   pnt_req_if.sink              req_bus,
   output logic                 out_valid,
   output logic [7:0]           out_byte,
   output logic [31:0]          out_scale,
   output pnt_pkg::pnt_tag_type out_tag
);
   import pnt_pkg::*;

   localparam logic [PLANE_W-1:0] PLANE_MAX = PLANE_W'(MAX_PLANE);
   localparam logic [1:0] CH_FIRST = 2'd0;
   localparam logic [1:0] CH_LAST  = 2'd2;

   logic               busy_ff, busy_in;
   logic [1:0]         ch_ff, ch_in;
   logic [7:0]         a_ff, b_ff, c_ff;
   logic [31:0]        base_ff;
   logic [RUN_W-1:0]   run_ff, run_in;
   logic [IDX_W-1:0]   img_off_ff;
   logic               valid_ff;
   logic [7:0]         byte_ff, byte_in;
   logic [31:0]        scale_ff, scale_in;
   pnt_tag_type        tag_ff, tag_in;

   logic               three, nchw, rev;
   logic [PLANE_W-1:0] plane_eff;
   logic               last_now;
   logic               req_fire;
   logic [RUN_W-1:0]   pix_w, pix3, step;
   logic [9:0]         img3;
   logic [34:0]        img_prod;

   assign three     = cfg.mode[MODE_THREE];
   assign nchw      = cfg.mode[MODE_NCHW];
   assign rev       = cfg.mode[MODE_REV];
   assign plane_eff = (cfg.plane_size > PLANE_MAX) ? PLANE_MAX : cfg.plane_size;
   assign last_now  = !three || ch_ff == CH_LAST;

   assign req_bus.ready = en && (!busy_ff || last_now);
   assign req_fire      = req_bus.valid && req_bus.ready;

   assign pix_w    = RUN_W'(req_bus.pixel_index);
   assign pix3     = pix_w + (pix_w << 1);
   assign step     = nchw ? RUN_W'(plane_eff) : RUN_W'(1);
   assign img3     = three ? (10'(req_bus.image_index) + (10'(req_bus.image_index) << 1))
                           : 10'(req_bus.image_index);
   assign img_prod = 35'(img3) * 35'(plane_eff);

   always_comb begin
      busy_in = busy_ff;
      ch_in   = ch_ff;
      run_in  = run_ff;
      if (req_fire) begin
         busy_in = 1'b1;
         ch_in   = CH_FIRST;
         run_in  = (nchw || !three) ? pix_w : pix3;
      end else if (en && busy_ff) begin
         if (last_now) begin
            busy_in = 1'b0;
         end else begin
            ch_in  = ch_ff + 2'd1;
            run_in = run_ff + step;
         end
      end
   end

   always_comb begin
      case (ch_ff)
         2'd0: begin
            byte_in  = (rev && three) ? c_ff : a_ff;
            scale_in = cfg.scale[0];
            tag_in.bias = cfg.bias[0];
         end
         2'd1: begin
            byte_in  = b_ff;
            scale_in = cfg.scale[1];
            tag_in.bias = cfg.bias[1];
         end
         2'd2: begin
            byte_in  = rev ? a_ff : c_ff;
            scale_in = cfg.scale[2];
            tag_in.bias = cfg.bias[2];
         end
         default: begin
            byte_in  = a_ff;
            scale_in = cfg.scale[0];
            tag_in.bias = cfg.bias[0];
         end
      endcase
      tag_in.meta.element_index = img_off_ff + IDX_W'(base_ff) + IDX_W'(run_ff);
      tag_in.meta.is_last       = last_now;
      tag_in.meta.half          = cfg.mode[MODE_HALF];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         ch_ff    <= CH_FIRST;
         valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         ch_ff   <= ch_in;
         if (en) begin
            valid_ff <= busy_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      run_ff <= run_in;
      if (req_fire) begin
         a_ff       <= req_bus.chan_a;
         b_ff       <= req_bus.chan_b;
         c_ff       <= req_bus.chan_c;
         base_ff    <= req_bus.base_index;
         img_off_ff <= img_prod[IDX_W-1:0];
      end
      if (en) begin
         byte_ff  <= byte_in;
         scale_ff <= scale_in;
         tag_ff   <= tag_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_scale = scale_ff;
   assign out_tag   = tag_ff;

   `PNT_ASSERT_NEXT(a_accept_starts, clock, reset, req_fire, busy_ff && ch_ff == CH_FIRST)
   `PNT_ASSERT_IMP(a_ch_range, clock, reset, busy_ff, ch_ff != 2'd3)
   `PNT_ASSERT_NEXT(a_stall_holds, clock, reset, busy_ff && !en, busy_ff && $stable(ch_ff))

endmodule
`default_nettype wire

// File: sv/pnt_fmul.sv
// byte times fp32 scale: specials and exact integer product, one stage
`default_nettype none
module pnt_fmul (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            en,
   input  wire logic            in_valid,
   input  wire logic [7:0]      in_byte,
   input  wire logic [31:0]     in_scale,
   input  wire pnt_pkg::pnt_tag_type in_tag,
   output logic                 out_valid,
   output pnt_pkg::pnt_unr_type out_unr,
   output pnt_pkg::pnt_tag_type out_tag
);
   import pnt_pkg::*;

   logic        valid_ff;
   pnt_unr_type unr_ff, unr_in;
   pnt_tag_type tag_ff;

   logic [7:0]  se;
   logic [23:0] sig;

   assign se  = in_scale[30:23];
   assign sig = {se != 8'd0, in_scale[22:0]};

   always_comb begin
      unr_in.special   = 1'b0;
      unr_in.spec_bits = 32'd0;
      unr_in.sign      = in_scale[31];
      unr_in.mag       = 32'(in_byte) * 32'(sig);
      unr_in.expo      = ((se == 8'd0) ? 12'sd1 : signed'({4'b0, se})) - 12'sd150;
      if (se == 8'hFF) begin
         unr_in.special = 1'b1;
         if (in_scale[22:0] != 23'd0 || in_byte == 8'd0) begin
            unr_in.spec_bits = QNAN32;
         end else begin
            unr_in.spec_bits = {in_scale[31], INF32};
         end
      end else if (in_byte == 8'd0 || sig == 24'd0) begin
         unr_in.special   = 1'b1;
         unr_in.spec_bits = {in_scale[31], 31'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         unr_ff <= unr_in;
         tag_ff <= in_tag;
      end
   end

   assign out_valid = valid_ff;
   assign out_unr   = unr_ff;
   assign out_tag   = tag_ff;

endmodule
`default_nettype wire

// File: sv/pnt_fround.sv
// normalise and round to nearest even into fp32, three stages
`default_nettype none
module pnt_fround (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            en,
   input  wire logic            in_valid,
   input  wire pnt_pkg::pnt_unr_type in_unr,
   input  wire pnt_pkg::pnt_tag_type in_tag,
   output logic                 out_valid,
   output logic [31:0]          out_bits,
   output pnt_pkg::pnt_tag_type out_tag
);
   import pnt_pkg::*;

   // stage 1: leading zero count and biased exponent
   logic               v1_ff;
   logic               spc1_ff;
   logic [31:0]        spb1_ff;
   logic               sg1_ff;
   logic [31:0]        mag1_ff;
   logic [5:0]         lz1_ff, lz1_in;
   logic signed [11:0] be1_ff, be1_in;
   pnt_tag_type        tag1_ff;
   // stage 2: normalised significand
   logic               v2_ff;
   logic               spc2_ff;
   logic [31:0]        spb2_ff;
   logic               sg2_ff;
   logic [31:0]        n2_ff, n2_in;
   logic signed [11:0] be2_ff;
   pnt_tag_type        tag2_ff;
   // stage 3: packed result
   logic               v3_ff;
   logic [31:0]        bits3_ff, bits3_in;
   pnt_tag_type        tag3_ff;

   logic signed [11:0] sh;
   logic [5:0]         s;
   logic [63:0]        wide;
   logic [31:0]        q;
   logic               up;
   logic [31:0]        expf;
   logic [31:0]        res;

   assign lz1_in = lzc32(in_unr.mag);
   assign be1_in = in_unr.expo + 12'sd158 - signed'({6'b0, lz1_in});
   assign n2_in  = mag1_ff << lz1_ff;

   always_comb begin
      sh   = 12'sd9 - be2_ff;
      if (be2_ff >= 12'sd1) begin
         s = 6'd8;
      end else if (sh > 12'sd40) begin
         s = 6'd40;
      end else begin
         s = sh[5:0];
      end
      wide = {n2_ff, 32'd0} >> s;
      q    = wide[63:32];
      up   = wide[31] && ((|wide[30:0]) || q[0]);
      expf = (be2_ff >= 12'sd1) ? (32'(be2_ff - 12'sd1) << 23) : 32'd0;
      res  = expf + q + 32'(up);
      if (spc2_ff) begin
         bits3_in = spb2_ff;
      end else if (be2_ff >= 12'sd255) begin
         bits3_in = {sg2_ff, INF32};
      end else begin
         bits3_in = {sg2_ff, res[30:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         spc1_ff  <= in_unr.special;
         spb1_ff  <= in_unr.spec_bits;
         sg1_ff   <= in_unr.sign;
         mag1_ff  <= in_unr.mag;
         lz1_ff   <= lz1_in;
         be1_ff   <= be1_in;
         tag1_ff  <= in_tag;
         spc2_ff  <= spc1_ff;
         spb2_ff  <= spb1_ff;
         sg2_ff   <= sg1_ff;
         n2_ff    <= n2_in;
         be2_ff   <= be1_ff;
         tag2_ff  <= tag1_ff;
         bits3_ff <= bits3_in;
         tag3_ff  <= tag2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_bits  = bits3_ff;
   assign out_tag   = tag3_ff;

endmodule
`default_nettype wire

// File: sv/pnt_fadd.sv
// fp32 add of product and bias: compare and swap, then align and add
`default_nettype none
module pnt_fadd (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            en,
   input  wire logic            in_valid,
   input  wire logic [31:0]     in_bits,
   input  wire pnt_pkg::pnt_tag_type in_tag,
   output logic                 out_valid,
   output pnt_pkg::pnt_unr_type out_unr,
   output pnt_pkg::pnt_tag_type out_tag
);
   import pnt_pkg::*;

   logic        v1_ff;
   logic        spc1_ff, spc1_in;
   logic [31:0] spb1_ff, spb1_in;
   logic        sg1_ff;
   logic [23:0] sx1_ff, sx1_in, sy1_ff, sy1_in;
   logic [4:0]  d1_ff, d1_in;
   logic [7:0]  ex1_ff, ex1_in;
   logic        sub1_ff;
   pnt_tag_type tag1_ff;

   logic        v2_ff;
   pnt_unr_type unr2_ff, unr2_in;
   pnt_tag_type tag2_ff;

   logic [31:0] a, b, x, y;
   logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
   logic [7:0]  ey;
   logic [7:0]  dd;
   logic [26:0] mx, my;
   logic [58:0] w;
   logic [27:0] sum;

   assign a      = in_bits;
   assign b      = in_tag.bias;
   assign a_nan  = a[30:23] == 8'hFF && a[22:0] != 23'd0;
   assign b_nan  = b[30:23] == 8'hFF && b[22:0] != 23'd0;
   assign a_inf  = a[30:0] == INF32;
   assign b_inf  = b[30:0] == INF32;
   assign a_zero = a[30:0] == 31'd0;
   assign b_zero = b[30:0] == 31'd0;

   always_comb begin
      if (a[30:0] >= b[30:0]) begin
         x = a;
         y = b;
      end else begin
         x = b;
         y = a;
      end
      ex1_in = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
      ey     = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
      dd     = ex1_in - ey;
      d1_in  = (dd > 8'd31) ? 5'd31 : dd[4:0];
      sx1_in = {x[30:23] != 8'd0, x[22:0]};
      sy1_in = {y[30:23] != 8'd0, y[22:0]};
      spc1_in = 1'b1;
      spb1_in = 32'd0;
      if (a_nan || b_nan || (a_inf && b_inf && a[31] != b[31])) begin
         spb1_in = QNAN32;
      end else if (a_inf) begin
         spb1_in = a;
      end else if (b_inf) begin
         spb1_in = b;
      end else if (a_zero && b_zero) begin
         spb1_in = {a[31] && b[31], 31'd0};
      end else if (a_zero) begin
         spb1_in = b;
      end else if (b_zero) begin
         spb1_in = a;
      end else begin
         spc1_in = 1'b0;
      end
   end

   // alignment keeps guard, round and a sticky bit below the significand
   always_comb begin
      mx  = {sx1_ff, 3'b0};
      w   = {sy1_ff, 3'b0, 32'd0} >> d1_ff;
      my  = {w[58:33], w[32] | (|w[31:0])};
      sum = sub1_ff ? ({1'b0, mx} - {1'b0, my}) : ({1'b0, mx} + {1'b0, my});
      unr2_in.special   = spc1_ff;
      unr2_in.spec_bits = spb1_ff;
      unr2_in.sign      = sg1_ff;
      unr2_in.mag       = {sum, 4'b0};
      unr2_in.expo      = signed'({4'b0, ex1_ff}) - 12'sd157;
      if (!spc1_ff && sum == 28'd0) begin
         unr2_in.special   = 1'b1;
         unr2_in.spec_bits = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         spc1_ff <= spc1_in;
         spb1_ff <= spb1_in;
         sg1_ff  <= x[31];
         sx1_ff  <= sx1_in;
         sy1_ff  <= sy1_in;
         d1_ff   <= d1_in;
         ex1_ff  <= ex1_in;
         sub1_ff <= a[31] ^ b[31];
         tag1_ff <= in_tag;
         unr2_ff <= unr2_in;
         tag2_ff <= tag1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_unr   = unr2_ff;
   assign out_tag   = tag2_ff;

endmodule
`default_nettype wire

// File: sv/pnt_half.sv
// nan canonicalising, optional fp16 rounding and the response register
`default_nettype none
module pnt_half (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            en,
   input  wire logic            in_valid,
   input  wire logic [31:0]     in_bits,
   input  wire pnt_pkg::pnt_tag_type in_tag,
   output logic                 out_valid,
   output logic [31:0]          out_value,
   output pnt_pkg::pnt_meta_type out_meta
);
   import pnt_pkg::*;

   logic         valid_ff;
   logic [31:0]  value_ff, value_in;
   pnt_meta_type meta_ff;

   logic         is_nan;
   logic [31:0]  f;

   assign is_nan   = in_bits[30:23] == 8'hFF && in_bits[22:0] != 23'd0;
   assign f        = is_nan ? QNAN32 : in_bits;
   assign value_in = in_tag.meta.half ? {16'd0, to_half(f)} : f;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         value_ff <= value_in;
         meta_ff  <= in_tag.meta;
      end
   end

   assign out_valid = valid_ff;
   assign out_value = value_ff;
   assign out_meta  = meta_ff;

endmodule
`default_nettype wire

// File: sv/pixel_normalize_to_tensor.sv
// pixel normaliser: uint8 pixels to fp32/fp16 tensor elements with nchw/nhwc indexes
//
// req_bus carries one pixel (one or three channel bytes, pixel, image and base
// indexes); rsp_bus returns one transfer per channel, in output channel order,
// with is_last set on the final one. csr_we/csr_index/csr_wdata write the mode,
// plane size and per-channel scale and bias registers; write only while idle.
// A pixel enters a sequencer that issues one channel per cycle, unless rsp_bus
// stalls, into a pipeline: multiply, round, add (two stages), round, fp16 conversion.
// Throughput: one result per cycle while the pipeline is not held, so each pixel
// takes one result slot per channel on the single result channel.
// The sequencer registers the pixel, then each channel's operands, before the multiply.
// Reset (synchronous) empties the pipeline and restores the register defaults:
// single channel nhwc fp32, plane size one, unit scales and zero biases.
// When rsp_bus.ready is low with a response waiting, the whole pipeline holds;
// nothing is dropped, and req_bus.ready falls once the sequencer cannot move on.
`default_nettype none
module pixel_normalize_to_tensor (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata,
   pnt_req_if.sink          req_bus,
   pnt_rsp_if.source        rsp_bus
);
   import pnt_pkg::*;

   pnt_cfg_type  cfg_ff;
   logic         en;

   logic         seq_valid;
   logic [7:0]   seq_byte;
   logic [31:0]  seq_scale;
   pnt_tag_type  seq_tag;
   logic         mul_valid;
   pnt_unr_type  mul_unr;
   pnt_tag_type  mul_tag;
   logic         prd_valid;
   logic [31:0]  prd_bits;
   pnt_tag_type  prd_tag;
   logic         add_valid;
   pnt_unr_type  add_unr;
   pnt_tag_type  add_tag;
   logic         sum_valid;
   logic [31:0]  sum_bits;
   pnt_tag_type  sum_tag;
   logic         out_valid;
   logic [31:0]  out_value;
   pnt_meta_type out_meta;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode       <= 4'd0;
         cfg_ff.plane_size <= PLANE_W'(1);
         cfg_ff.scale      <= {ONE32, ONE32, ONE32};
         cfg_ff.bias       <= '0;
      end else if (csr_we) begin
         case (pnt_reg_type'(csr_index))
            REG_MODE:   cfg_ff.mode       <= csr_wdata[3:0];
            REG_PLANE:  cfg_ff.plane_size <= csr_wdata[PLANE_W-1:0];
            REG_SCALE0: cfg_ff.scale[0]   <= csr_wdata;
            REG_SCALE1: cfg_ff.scale[1]   <= csr_wdata;
            REG_SCALE2: cfg_ff.scale[2]   <= csr_wdata;
            REG_BIAS0:  cfg_ff.bias[0]    <= csr_wdata;
            REG_BIAS1:  cfg_ff.bias[1]    <= csr_wdata;
            REG_BIAS2:  cfg_ff.bias[2]    <= csr_wdata;
            default:    cfg_ff.mode       <= cfg_ff.mode;
         endcase
      end
   end

   // the whole pipeline moves whenever the response register is free
   assign en = !out_valid || rsp_bus.ready;

   pnt_chan_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg_ff),
      .req_bus   (req_bus),
      .out_valid (seq_valid),
      .out_byte  (seq_byte),
      .out_scale (seq_scale),
      .out_tag   (seq_tag)
   );

   pnt_fmul u_mul (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (seq_valid),
      .in_byte   (seq_byte),
      .in_scale  (seq_scale),
      .in_tag    (seq_tag),
      .out_valid (mul_valid),
      .out_unr   (mul_unr),
      .out_tag   (mul_tag)
   );

   pnt_fround u_mul_round (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (mul_valid),
      .in_unr    (mul_unr),
      .in_tag    (mul_tag),
      .out_valid (prd_valid),
      .out_bits  (prd_bits),
      .out_tag   (prd_tag)
   );

   pnt_fadd u_add (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (prd_valid),
      .in_bits   (prd_bits),
      .in_tag    (prd_tag),
      .out_valid (add_valid),
      .out_unr   (add_unr),
      .out_tag   (add_tag)
   );

   pnt_fround u_add_round (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (add_valid),
      .in_unr    (add_unr),
      .in_tag    (add_tag),
      .out_valid (sum_valid),
      .out_bits  (sum_bits),
      .out_tag   (sum_tag)
   );

   pnt_half u_half (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sum_valid),
      .in_bits   (sum_bits),
      .in_tag    (sum_tag),
      .out_valid (out_valid),
      .out_value (out_value),
      .out_meta  (out_meta)
   );

   assign rsp_bus.valid         = out_valid;
   assign rsp_bus.value         = out_value;
   assign rsp_bus.element_index = out_meta.element_index;
   assign rsp_bus.is_last       = out_meta.is_last;

endmodule
`default_nettype wire
